/* hw/rtl/mcconv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcconv_pkg
// Shared constants, payload types and opcodes for the depthwise causal conv.
// ----------------------------------------------------------------------------
package mcconv_pkg;

    localparam int CHANNELS     = 64;
    localparam int TAPS         = 4;
    localparam int SAMPLE_WIDTH = 16;

    localparam int DATA_W = 16;
    localparam int CHF_W  = 6;
    localparam int TAPF_W = 2;
    localparam int FRAC   = 8;

    localparam int VAL_W  = (SAMPLE_WIDTH < DATA_W) ? SAMPLE_WIDTH : DATA_W;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS + 1) + 1;

    localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
    localparam logic [1:0] OP_PUSH        = 2'd2;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [TAPS-1:0][VAL_W-1:0] win_t;

    typedef struct packed {
        logic [1:0]              op;
        logic [CHF_W-1:0]        channel;
        logic [TAPF_W-1:0]       tap;
        logic signed [DATA_W-1:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [CHF_W-1:0]         out_channel;
        logic signed [DATA_W-1:0] conv_result;
        logic                     saturated;
    } out_item_t;

    typedef struct packed {
        logic [CHF_W-1:0] ch;
        win_t             win;
        win_t             wt;
        val_t             bias;
    } tap_bundle_t;

endpackage

/* hw/rtl/mcconv_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcconv_store
// Weight, bias and history memories; history read-modify-write with bypass.
// ----------------------------------------------------------------------------
module mcconv_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  mcconv_pkg::in_item_t   item,
    output logic                   bnd_valid,
    input  logic                   bnd_ready,
    output mcconv_pkg::tap_bundle_t bnd
);
    import mcconv_pkg::*;

    win_t              hist_mem [CHANNELS];
    win_t              wt_mem   [CHANNELS];
    val_t              bias_mem [CHANNELS];

    win_t              hist_q_reg;
    win_t              wt_q_reg;
    val_t              bias_q_reg;
    logic [CHANNELS-1:0] hist_vld_reg;

    logic              s1_valid_reg;
    logic [CHF_W-1:0]  s1_ch_reg;
    val_t              s1_sample_reg;

    logic              byp_valid_reg;
    logic [CH_W-1:0]   byp_ch_reg;
    win_t              byp_win_reg;

    logic              accept;
    logic              ch_ok;
    logic              tap_ok;
    logic              push_ok;
    logic              advance;
    logic [CH_W-1:0]   ch_idx;
    logic [TAP_W-1:0]  tap_idx;
    logic [CH_W-1:0]   s1_idx;
    val_t              in_val;
    win_t              win_old;
    win_t              win_new;

    assign item_ready = !s1_valid_reg || bnd_ready;
    assign accept     = item_valid && item_ready;
    assign ch_idx     = CH_W'(item.channel);
    assign tap_idx    = TAP_W'(item.tap);
    assign ch_ok      = (int'(item.channel) < CHANNELS);
    assign tap_ok     = (int'(item.tap) < TAPS);
    assign push_ok    = accept && ch_ok && (item.op == OP_PUSH);
    assign in_val     = val_t'(item.data_word[VAL_W-1:0]);
    assign s1_idx     = CH_W'(s1_ch_reg);
    assign advance    = s1_valid_reg && bnd_ready;

    // weight and bias loads write on acceptance
    always_ff @(posedge clk)
    begin
        if (accept && ch_ok && (item.op == OP_LOAD_WEIGHT) && tap_ok)
        begin
            wt_mem[ch_idx][tap_idx] <= in_val;
        end
        if (accept)
        begin
            wt_q_reg <= wt_mem[ch_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ch_ok && (item.op == OP_LOAD_BIAS))
        begin
            bias_mem[ch_idx] <= in_val;
        end
        if (accept)
        begin
            bias_q_reg <= bias_mem[ch_idx];
        end
    end

    // history window, forwarded from the previous write on a channel match
    always_comb
    begin
        if (byp_valid_reg && (byp_ch_reg == s1_idx))
        begin
            win_old = byp_win_reg;
        end
        else if (hist_vld_reg[s1_idx])
        begin
            win_old = hist_q_reg;
        end
        else
        begin
            win_old = '0;
        end
        win_new = win_old;
        for (int k = 0; k < TAPS - 1; k++)
        begin
            win_new[k] = win_old[k + 1];
        end
        win_new[TAPS-1] = s1_sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hist_mem[s1_idx] <= win_new;
        end
        if (accept)
        begin
            hist_q_reg <= hist_mem[ch_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            hist_vld_reg  <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                s1_valid_reg <= push_ok;
            end
            if (advance)
            begin
                byp_valid_reg        <= 1'b1;
                hist_vld_reg[s1_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            s1_ch_reg     <= item.channel;
            s1_sample_reg <= in_val;
        end
        if (advance)
        begin
            byp_ch_reg  <= s1_idx;
            byp_win_reg <= win_new;
        end
    end

    assign bnd_valid = s1_valid_reg;
    assign bnd.ch    = s1_ch_reg;
    assign bnd.win   = win_new;
    assign bnd.wt    = wt_q_reg;
    assign bnd.bias  = bias_q_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> s1_valid_reg)
        else $error("input stalled with empty read stage");

    a_push_enters: assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> s1_valid_reg && (s1_ch_reg == $past(item.channel)))
        else $error("accepted push did not reach read stage");

    a_bypass_marked: assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> hist_vld_reg[byp_ch_reg])
        else $error("bypassed row not marked valid");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !push_ok |=> !s1_valid_reg)
        else $error("history write repeated for one push");

endmodule

/* hw/rtl/mcconv_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcconv_mac
// Tap multiply, accumulate with bias, round to nearest and saturate.
// ----------------------------------------------------------------------------
module mcconv_mac (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    bnd_valid,
    output logic                    bnd_ready,
    input  mcconv_pkg::tap_bundle_t bnd,
    output logic                    result_valid,
    input  logic                    result_ready,
    output mcconv_pkg::out_item_t   result
);
    import mcconv_pkg::*;

    localparam acc_t RND_POS = acc_t'(1 << (FRAC - 1));
    localparam acc_t RND_NEG = acc_t'((1 << (FRAC - 1)) - 1);
    localparam acc_t VMAX    = acc_t'((1 << (VAL_W - 1)) - 1);
    localparam acc_t VMIN    = acc_t'(-(1 << (VAL_W - 1)));
    localparam logic signed [DATA_W-1:0] OUT_MAX = DATA_W'(VMAX);
    localparam logic signed [DATA_W-1:0] OUT_MIN = DATA_W'(VMIN);

    logic                 p_valid_reg;
    prod_t [TAPS-1:0]     p_prod_reg;
    val_t                 p_bias_reg;
    logic [CHF_W-1:0]     p_ch_reg;

    logic                 a_valid_reg;
    acc_t                 a_acc_reg;
    logic [CHF_W-1:0]     a_ch_reg;

    logic                 o_valid_reg;
    out_item_t            o_item_reg;

    logic                 p_en;
    logic                 a_en;
    logic                 o_en;
    prod_t [TAPS-1:0]     p_prod_next;
    acc_t                 a_acc_next;
    acc_t                 rnd;
    acc_t                 q;
    acc_t                 q_sat;
    logic                 sat;
    out_item_t            o_item_next;

    assign o_en      = !o_valid_reg || result_ready;
    assign a_en      = !a_valid_reg || o_en;
    assign p_en      = !p_valid_reg || a_en;
    assign bnd_ready = p_en;

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            p_prod_next[k] = prod_t'(signed'(bnd.win[k])) * prod_t'(signed'(bnd.wt[k]));
        end
    end

    always_comb
    begin
        a_acc_next = acc_t'(p_bias_reg) <<< FRAC;
        for (int k = 0; k < TAPS; k++)
        begin
            a_acc_next = a_acc_next + acc_t'(signed'(p_prod_reg[k]));
        end
    end

    // ties round away from zero
    always_comb
    begin
        rnd = a_acc_reg + (a_acc_reg[ACC_W-1] ? RND_NEG : RND_POS);
        q   = rnd >>> FRAC;
        priority if (q > VMAX)
        begin
            q_sat = VMAX;
            sat   = 1'b1;
        end
        else if (q < VMIN)
        begin
            q_sat = VMIN;
            sat   = 1'b1;
        end
        else
        begin
            q_sat = q;
            sat   = 1'b0;
        end
        o_item_next.out_channel = a_ch_reg;
        o_item_next.conv_result = DATA_W'(signed'(q_sat[VAL_W-1:0]));
        o_item_next.saturated   = sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_en)
            begin
                p_valid_reg <= bnd_valid;
            end
            if (a_en)
            begin
                a_valid_reg <= p_valid_reg;
            end
            if (o_en)
            begin
                o_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_en && bnd_valid)
        begin
            p_prod_reg <= p_prod_next;
            p_bias_reg <= bnd.bias;
            p_ch_reg   <= bnd.ch;
        end
        if (a_en && p_valid_reg)
        begin
            a_acc_reg <= a_acc_next;
            a_ch_reg  <= p_ch_reg;
        end
        if (o_en && a_valid_reg)
        begin
            o_item_reg <= o_item_next;
        end
    end

    assign result_valid = o_valid_reg;
    assign result       = o_item_reg;

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_item_reg.saturated |->
            (o_item_reg.conv_result == OUT_MAX) || (o_item_reg.conv_result == OUT_MIN))
        else $error("saturation flag without clamped value");

    a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(a_valid_reg))
        else $error("result appeared without accumulator stage");

    a_acc_holds: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !o_en |=> a_valid_reg && $stable(a_acc_reg))
        else $error("accumulator lost under stall");

endmodule

/* hw/rtl/multichannel_causal_conv1d_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_causal_conv1d_top
// Depthwise causal FIR per channel with weight, bias and sample item types.
// ----------------------------------------------------------------------------
// path: a push passes the read stage, then the product, accumulator and output registers
// throughput: one item per cycle while results drain, set by the single history
//   read-modify-write port, with a one-entry bypass for back-to-back same-channel pushes
// reset: history rows read as zero through per-row valid bits, no clearing pass
// reset: weights and bias hold no defined value until loaded
// ----------------------------------------------------------------------------
module multichannel_causal_conv1d_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  mcconv_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output mcconv_pkg::out_item_t result
);
    import mcconv_pkg::*;

    logic        bnd_valid;
    logic        bnd_ready;
    tap_bundle_t bnd;

    mcconv_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .bnd_valid  (bnd_valid),
        .bnd_ready  (bnd_ready),
        .bnd        (bnd)
    );

    mcconv_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .bnd_valid    (bnd_valid),
        .bnd_ready    (bnd_ready),
        .bnd          (bnd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* tb/sv/mcconv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcconv_checker
// Watches the item and result channels of the depthwise causal conv. Each accepted
// load or push updates a local copy of the weights, biases and sample windows. Each push
// queues the rounded, saturated filter output. Every result transfer is
// compared field by field against the oldest queued output.
// ----------------------------------------------------------------------------
module mcconv_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic                  item_ready,
    input  mcconv_pkg::in_item_t  item,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  mcconv_pkg::out_item_t result,
    output int                    errors,
    output int                    outstanding
);
    import mcconv_pkg::*;

    val_t      window   [CHANNELS][TAPS];
    val_t      tap_wt   [CHANNELS][TAPS];
    val_t      ch_bias  [CHANNELS];
    out_item_t pending_outputs [$];
    out_item_t want;

    function automatic out_item_t filter_output(input int ch);
        longint    acc;
        longint    q;
        longint    vmax;
        longint    vmin;
        int        k;
        out_item_t r;
        acc = longint'(ch_bias[ch]) * 256;
        for (k = 0; k < TAPS; k++)
        begin
            acc += longint'(tap_wt[ch][k]) * longint'(window[ch][k]);
        end
        // round half away from zero
        if (acc >= 0)
            q = (acc + 128) >>> FRAC;
        else
            q = -((-acc + 128) >>> FRAC);
        vmax = (longint'(1) << (VAL_W - 1)) - 1;
        vmin = -vmax - 1;
        r.saturated = 1'b0;
        if (q > vmax)
        begin
            q = vmax;
            r.saturated = 1'b1;
        end
        if (q < vmin)
        begin
            q = vmin;
            r.saturated = 1'b1;
        end
        r.out_channel = CHF_W'(ch);
        r.conv_result = q[DATA_W-1:0];
        return r;
    endfunction

    initial
    begin
        errors = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        int   ch;
        int   k;
        val_t v;
        if (!rst_n)
        begin
            for (ch = 0; ch < CHANNELS; ch++)
            begin
                for (k = 0; k < TAPS; k++)
                begin
                    window[ch][k] = '0;
                end
            end
            pending_outputs.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $display("%0t: unexpected result transfer ch=%0d value=%0d sat=%0b",
                             $time, result.out_channel, result.conv_result,
                             result.saturated);
                    errors++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (want.out_channel !== result.out_channel)
                    begin
                        $display("%0t: out_channel expected %0d actual %0d",
                                 $time, want.out_channel, result.out_channel);
                        errors++;
                    end
                    if (want.conv_result !== result.conv_result)
                    begin
                        $display("%0t: conv_result ch %0d expected %0d actual %0d",
                                 $time, want.out_channel, want.conv_result,
                                 result.conv_result);
                        errors++;
                    end
                    if (want.saturated !== result.saturated)
                    begin
                        $display("%0t: saturated ch %0d expected %0b actual %0b",
                                 $time, want.out_channel, want.saturated,
                                 result.saturated);
                        errors++;
                    end
                end
            end
            if (item_valid && item_ready && item.channel < CHANNELS)
            begin
                ch = item.channel;
                v  = item.data_word[VAL_W-1:0];
                case (item.op)
                    OP_LOAD_WEIGHT:
                    begin
                        if (item.tap < TAPS)
                            tap_wt[ch][item.tap] = v;
                    end
                    OP_LOAD_BIAS:
                    begin
                        ch_bias[ch] = v;
                    end
                    OP_PUSH:
                    begin
                        for (k = 0; k < TAPS - 1; k++)
                        begin
                            window[ch][k] = window[ch][k + 1];
                        end
                        window[ch][TAPS - 1] = v;
                        pending_outputs.push_back(filter_output(ch));
                    end
                    default:
                    begin
                    end
                endcase
            end
            outstanding = pending_outputs.size();
        end
    end

endmodule

/* tb/sv/multichannel_causal_conv1d_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_causal_conv1d_top_tb
// Drives weight, bias and sample transfers into the depthwise causal conv,
// with random idle cycles on both channels, and lets the checker compare
// every filter output. Directed extremes, rounding ties and saturation come
// first, then random traffic that only pushes into fully loaded channels.
// ----------------------------------------------------------------------------
module multichannel_causal_conv1d_top_tb;
    import mcconv_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1925;
    localparam int         CYCLE_LIMIT  = 400000;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    logic      item_ready;
    in_item_t  item         = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    int        errors;
    int        outstanding;
    int        cycle_count  = 0;
    bit        src_calm     = 1'b0;
    bit        snk_calm     = 1'b0;
    bit [4:0]  loaded [CHANNELS];

    multichannel_causal_conv1d_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    mcconv_checker conv_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int idle_cycles(input bit calm);
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 3))
            0:       return DATA_W'($urandom);
            1:       return DATA_W'(int'($urandom_range(0, 1023)) - 512);
            2:       return DATA_W'(int'($urandom_range(0, 65535)) >> $urandom_range(4, 15));
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task automatic send_item(input logic [1:0] op, input int ch, input int tp,
                             input logic [DATA_W-1:0] data);
        int gap;
        in_item_t it;
        it.op        = op;
        it.channel   = CHF_W'(ch);
        it.tap       = TAPF_W'(tp);
        it.data_word = data;
        gap = idle_cycles(src_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic load_weight(input int ch, input int tp, input logic [DATA_W-1:0] data);
        send_item(OP_LOAD_WEIGHT, ch, tp, data);
        loaded[ch][tp] = 1'b1;
    endtask

    task automatic load_bias(input int ch, input logic [DATA_W-1:0] data);
        send_item(OP_LOAD_BIAS, ch, 0, data);
        loaded[ch][4] = 1'b1;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // result side: random stall before each transfer
    initial
    begin
        int gap;
        int served;
        served = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                snk_calm = ~snk_calm;
            gap = idle_cycles(snk_calm);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            served++;
        end
    end

    initial
    begin
        int sent;
        int sel;
        int ch;
        int tp;
        int k;
        for (ch = 0; ch < CHANNELS; ch++)
        begin
            loaded[ch] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unity end taps, most negative bias, sample extremes
        load_weight(0, 0, 16'h0100);
        load_weight(0, 1, 16'h0000);
        load_weight(0, 2, 16'h0000);
        load_weight(0, 3, 16'h0100);
        load_bias(0, 16'h8000);
        send_item(OP_PUSH, 0, 0, 16'h7FFF);
        send_item(OP_PUSH, 0, 0, 16'h8000);
        send_item(OP_PUSH, 0, 0, 16'h0000);
        send_item(OP_PUSH, 0, 0, 16'h0001);
        // unused op with every field bit set
        send_item(OP_UNUSED, CHANNELS - 1, TAPS - 1, 16'hFFFF);
        // saturation both ways
        for (k = 0; k < TAPS; k++)
        begin
            load_weight(CHANNELS - 1, k, 16'h7FFF);
        end
        load_bias(CHANNELS - 1, 16'h7FFF);
        send_item(OP_PUSH, CHANNELS - 1, 0, 16'h7FFF);
        send_item(OP_PUSH, CHANNELS - 1, 0, 16'h8000);
        send_item(OP_PUSH, CHANNELS - 1, 0, 16'h8000);
        // rounding ties away from zero
        load_weight(1, 0, 16'h0000);
        load_weight(1, 1, 16'h0000);
        load_weight(1, 2, 16'h0000);
        load_weight(1, 3, 16'h0001);
        load_bias(1, 16'h0000);
        send_item(OP_PUSH, 1, 0, 16'h0080);
        send_item(OP_PUSH, 1, 0, 16'hFF80);
        wait_idle();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 80) == 0)
                src_calm = ~src_calm;
            if (sent == RANDOM_ITEMS / 2)
            begin
                wait_idle();
                sent++;
                continue;
            end
            sel = $urandom_range(0, 99);
            ch  = $urandom_range(0, CHANNELS - 1);
            tp  = $urandom_range(0, TAPS - 1);
            if (sel < 6)
            begin
                send_item(OP_UNUSED, ch, tp, rand_word());
                sent++;
                continue;
            end
            if (sel < 16)
                load_weight(ch, tp, rand_word());
            else if (sel < 22)
                load_bias(ch, rand_word());
            else if (loaded[ch] != 5'h1F)
            begin
                if (!loaded[ch][4])
                    load_bias(ch, rand_word());
                else
                begin
                    for (k = TAPS - 1; k >= 0; k--)
                    begin
                        if (!loaded[ch][k])
                            tp = k;
                    end
                    load_weight(ch, tp, rand_word());
                end
            end
            else
                send_item(OP_PUSH, ch, tp, rand_word());
            sent++;
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
